@@ sv/mau_pkg.sv @@
// ----------------------------------------------------------------------------
// mau_pkg: shared types and constants for the modular arithmetic unit
// Widths, operation codes, sequencer states and the divider control bundle.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int unsigned ModBits = 31;
  localparam int unsigned ExpBits = 63;
  localparam int unsigned RawBits = 64;
  localparam int unsigned DivBits = 64;
  localparam int unsigned DivCntBits = $clog2(DivBits);

  localparam logic [ModBits-1:0] ModulusReset = ModBits'(1000000007);

  typedef enum logic [2:0] {
    OpReduce   = 3'd0,
    OpAdd      = 3'd1,
    OpSub      = 3'd2,
    OpMul      = 3'd3,
    OpPow      = 3'd4,
    OpDiv      = 3'd5,
    OpRsvd6    = 3'd6,
    OpRsvd7    = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    StIdle,
    StRedA,
    StRedB,
    StRedRaw,
    StDispatch,
    StPowStep,
    StPowMul,
    StPowSq,
    StDivFinal,
    StDone
  } state_e;

  // Request to the shared remainder unit.
  typedef struct packed {
    logic               start;
    logic [DivBits-1:0] dividend;
  } rem_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [ModBits-1:0] rem;
  } rem_rsp_t;

endpackage

@@ sv/mau_rem.sv @@
// ----------------------------------------------------------------------------
// mau_rem: restoring remainder unit
// 64-bit dividend mod 31-bit modulus, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mau_rem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [mau_pkg::ModBits-1:0]  modulus_i,
  input  mau_pkg::rem_req_t            req_i,
  output mau_pkg::rem_rsp_t            rsp_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [mau_pkg::DivCntBits-1:0]   cnt_q, cnt_d;
  logic [mau_pkg::DivBits-1:0]      sh_q, sh_d;
  logic [mau_pkg::ModBits-1:0]      rem_q, rem_d;
  logic [mau_pkg::ModBits:0]        trial;
  logic [mau_pkg::ModBits:0]        diff;

  // partial remainder stays below modulus, so shifted value fits ModBits+1
  assign trial = {rem_q, sh_q[mau_pkg::DivBits-1]};
  assign diff  = trial - {1'b0, modulus_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = req_i.dividend;
      rem_d  = '0;
    end else if (busy_q) begin
      sh_d = {sh_q[mau_pkg::DivBits-2:0], 1'b0};
      if (!diff[mau_pkg::ModBits]) begin
        rem_d = diff[mau_pkg::ModBits-1:0];
      end else begin
        rem_d = trial[mau_pkg::ModBits-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == mau_pkg::DivCntBits'(mau_pkg::DivBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ sv/modular_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// modular_arithmetic_unit: residue arithmetic modulo a programmable prime
// Reduce, add, subtract, multiply, power and Fermat-inverse divide.
// ----------------------------------------------------------------------------
// Channel | Signals                                        | Dir
// --------+------------------------------------------------+----
// req     | req_valid_i, req_stall_o, req_type_i, lhs_i,   | in
//         | rhs_i, exponent_i, raw_value_i                 |
// rsp     | rsp_valid_o, rsp_stall_i, residue_o            | out
// cfg     | cfg_we_i, cfg_wdata_i                          | in
//
// One item at a time. Operands, the raw value and every product are reduced
// in the shared remainder unit, which steps through all 64 dividend bits.
// Add/sub take 2 reductions; reduce and mul take 3; power takes 2 reductions
// plus one per exponent bit up to its top set bit, two for a set bit;
// divide is a power by modulus-2 (at most 31 bits) plus one multiply.
// Reset clears control only; the modulus register resets to 1000000007.
// The req side stalls while an item is in flight; a finished residue sits
// in the output register until taken.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mau_pkg::ModBits-1:0]  cfg_wdata_i,
  input  logic                         req_valid_i,
  output logic                         req_stall_o,
  input  logic [2:0]                   req_type_i,
  input  logic [mau_pkg::ModBits-1:0]  lhs_i,
  input  logic [mau_pkg::ModBits-1:0]  rhs_i,
  input  logic [mau_pkg::ExpBits-1:0]  exponent_i,
  input  logic signed [mau_pkg::RawBits-1:0] raw_value_i,
  output logic                         rsp_valid_o,
  input  logic                         rsp_stall_i,
  output logic [mau_pkg::ModBits-1:0]  residue_o
);

  mau_pkg::state_e state_q, state_d;

  logic [mau_pkg::ModBits-1:0] modulus_q;
  logic [2:0]                  op_q;
  logic [mau_pkg::ModBits-1:0] a_q, b_q, acc_q, sq_q, res_q;
  logic [mau_pkg::ExpBits-1:0] e_q;
  logic [mau_pkg::RawBits-1:0] raw_q;
  logic                        neg_q;
  logic                        deg;

  mau_pkg::rem_req_t rem_req;
  mau_pkg::rem_rsp_t rem_rsp;

  // wait flag: a reduction was issued and its answer is pending
  logic                        wait_q, wait_d;
  logic                        fire;

  logic [2*mau_pkg::ModBits-1:0] prod;
  logic [mau_pkg::ModBits-1:0]   mul_x, mul_y;
  logic [mau_pkg::ModBits:0]     sum;
  logic [mau_pkg::RawBits-1:0]   mag;
  logic [mau_pkg::ModBits-1:0]   rr;

  assign deg     = (modulus_q < mau_pkg::ModBits'(2));
  assign req_stall_o = (state_q != mau_pkg::StIdle);
  assign fire    = req_valid_i && !req_stall_o;
  assign rr      = rem_rsp.rem;
  assign mag     = neg_q ? (~raw_q + 1'b1) : raw_q;
  assign prod    = mul_x * mul_y;

  mau_rem u_rem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .modulus_i(modulus_q),
    .req_i    (rem_req),
    .rsp_o    (rem_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mau_pkg::StIdle:     if (fire) state_d = mau_pkg::StRedA;
      mau_pkg::StRedA:     if (rem_rsp.done) state_d = mau_pkg::StRedB;
      mau_pkg::StRedB:     if (rem_rsp.done) state_d = mau_pkg::StRedRaw;
      mau_pkg::StRedRaw:   if (rem_rsp.done || op_q != mau_pkg::OpReduce)
                             state_d = mau_pkg::StDispatch;
      mau_pkg::StDispatch: begin
        if (deg) begin
          state_d = mau_pkg::StDone;
        end else begin
          priority case (op_q)
            mau_pkg::OpMul:  if (rem_rsp.done) state_d = mau_pkg::StDone;
            mau_pkg::OpPow,
            mau_pkg::OpDiv:  state_d = mau_pkg::StPowStep;
            default:         state_d = mau_pkg::StDone;
          endcase
        end
      end
      mau_pkg::StPowStep: begin
        if (e_q == '0) begin
          state_d = (op_q == mau_pkg::OpDiv) ? mau_pkg::StDivFinal : mau_pkg::StDone;
        end else if (e_q[0]) begin
          state_d = mau_pkg::StPowMul;
        end else begin
          state_d = mau_pkg::StPowSq;
        end
      end
      mau_pkg::StPowMul:   if (rem_rsp.done) state_d = mau_pkg::StPowSq;
      mau_pkg::StPowSq:    if (rem_rsp.done) state_d = mau_pkg::StPowStep;
      mau_pkg::StDivFinal: if (rem_rsp.done) state_d = mau_pkg::StDone;
      mau_pkg::StDone:     if (!rsp_stall_i) state_d = mau_pkg::StIdle;
      default:             state_d = mau_pkg::StIdle;
    endcase
  end

  // multiplier operand select (one 31x31 multiplier, registered into divider)
  always_comb begin
    mul_x = acc_q;
    mul_y = sq_q;
    unique case (state_q)
      mau_pkg::StPowSq:    begin mul_x = sq_q; mul_y = sq_q; end
      mau_pkg::StDivFinal: begin mul_x = a_q;  mul_y = acc_q; end
      mau_pkg::StDispatch: begin mul_x = a_q;  mul_y = b_q; end
      default:             ;
    endcase
  end

  // reduction requests: issue once on entry, wait for done
  always_comb begin
    rem_req.start    = 1'b0;
    rem_req.dividend = '0;
    wait_d           = wait_q;
    if (rem_rsp.done) wait_d = 1'b0;
    if (!wait_q && !rem_rsp.done) begin
      unique case (state_q)
        mau_pkg::StRedA: begin
          rem_req.start = 1'b1; rem_req.dividend = mau_pkg::DivBits'(a_q);
        end
        mau_pkg::StRedB: begin
          rem_req.start = 1'b1; rem_req.dividend = mau_pkg::DivBits'(b_q);
        end
        mau_pkg::StRedRaw: begin
          rem_req.start = (op_q == mau_pkg::OpReduce); rem_req.dividend = mag;
        end
        mau_pkg::StDispatch: begin
          rem_req.start = (op_q == mau_pkg::OpMul) && !deg;
          rem_req.dividend = mau_pkg::DivBits'(prod);
        end
        mau_pkg::StPowMul, mau_pkg::StPowSq, mau_pkg::StDivFinal: begin
          rem_req.start = 1'b1; rem_req.dividend = mau_pkg::DivBits'(prod);
        end
        default: ;
      endcase
    end
    if (rem_req.start) wait_d = 1'b1;
  end

  always_comb begin
    sum = {1'b0, a_q} + {1'b0, b_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mau_pkg::StIdle;
      modulus_q <= mau_pkg::ModulusReset;
      wait_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      if (cfg_we_i) modulus_q <= cfg_wdata_i;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (fire) begin
      op_q  <= req_type_i;
      a_q   <= lhs_i;
      b_q   <= rhs_i;
      e_q   <= exponent_i;
      raw_q <= raw_value_i;
      neg_q <= raw_value_i[mau_pkg::RawBits-1];
      res_q <= '0;
    end
    unique case (state_q)
      mau_pkg::StRedA:   if (rem_rsp.done) a_q <= rr;
      mau_pkg::StRedB:   if (rem_rsp.done) b_q <= rr;
      mau_pkg::StRedRaw: if (rem_rsp.done) begin
        res_q <= (neg_q && rr != '0) ? (modulus_q - rr) : rr;
      end
      mau_pkg::StDispatch: begin
        acc_q <= mau_pkg::ModBits'(1);
        if (op_q == mau_pkg::OpDiv) begin
          sq_q <= b_q;
          e_q  <= mau_pkg::ExpBits'(modulus_q - mau_pkg::ModBits'(2));
        end else begin
          sq_q <= a_q;
        end
        if (deg) begin
          res_q <= '0;
        end else begin
          priority case (op_q)
            mau_pkg::OpReduce: ;
            mau_pkg::OpAdd:
              res_q <= (sum >= {1'b0, modulus_q}) ?
                       mau_pkg::ModBits'(sum - {1'b0, modulus_q}) : sum[mau_pkg::ModBits-1:0];
            mau_pkg::OpSub:
              res_q <= (a_q >= b_q) ? (a_q - b_q) : (a_q + modulus_q - b_q);
            mau_pkg::OpMul: if (rem_rsp.done) res_q <= rr;
            default: res_q <= '0;
          endcase
        end
      end
      mau_pkg::StPowStep: if (e_q == '0) begin
        if (op_q == mau_pkg::OpPow) res_q <= acc_q;
        if (op_q == mau_pkg::OpDiv && b_q == '0) acc_q <= '0;
      end
      mau_pkg::StPowMul: if (rem_rsp.done) acc_q <= rr;
      mau_pkg::StPowSq: if (rem_rsp.done) begin
        sq_q <= rr;
        e_q  <= e_q >> 1;
      end
      mau_pkg::StDivFinal: if (rem_rsp.done) res_q <= rr;
      default: ;
    endcase
  end

  assign rsp_valid_o = (state_q == mau_pkg::StDone);
  assign residue_o   = res_q;

endmodule
